>>> rtl/gme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph mask expander package
// Shared widths, defaults, register indexes, controller types and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package gme_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned COORD_W   = 11;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned LEVELS_W  = 9;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 11;

  // Width used when comparing a register against a dimension limit.
  localparam int unsigned DIM_CMP_W = 13;

  // Parameter defaults.
  localparam int unsigned DEF_MAX_WIDTH    = 1024;
  localparam int unsigned DEF_MAX_HEIGHT   = 1024;
  localparam int unsigned DEF_GUARD_PIXELS = 1;

  // Register reset values.
  localparam logic [COORD_W-1:0]  RST_SRC_WIDTH   = COORD_W'(1);
  localparam logic [COORD_W-1:0]  RST_SRC_HEIGHT  = COORD_W'(1);
  localparam logic [LEVELS_W-1:0] RST_GRAY_LEVELS = LEVELS_W'(256);

  // Alpha for a fully covered pixel and the level count that means copy.
  localparam logic [BYTE_W-1:0]   ALPHA_FULL  = 8'hFF;
  localparam logic [LEVELS_W-1:0] LEVELS_COPY = LEVELS_W'(256);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH     = 3'd0,
    CFG_SRC_HEIGHT    = 3'd1,
    CFG_PIXEL_MODE    = 3'd2,
    CFG_GRAY_LEVELS   = 3'd3,
    CFG_ROWS_REVERSED = 3'd4
  } cfg_index_e;

  // Pixel mode codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_GRAY = 2'd0,
    MODE_MONO = 2'd1
  } pixel_mode_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } ctrl_state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // take the input word, rewrap counters, seed divider
    logic div_step;  // one restoring division step
    logic emit;      // present one pixel to the output register
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic mode_err;  // unsupported pixel mode
    logic need_div;  // neither mono nor gray copy: scaling needed
    logic div_last;  // current division step is the eighth
    logic pix_last;  // current pixel is the last one of the word
    logic out_free;  // output register can take a pixel this cycle
  } ctrl_status_t;

endpackage

>>> rtl/gme_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph mask expander controller
// Sequences one input word at a time: accept, optional gray division,
// then one output pixel per cycle while the output register is free.
// ----------------------------------------------------------------------------
module gme_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  gme_pkg::ctrl_status_t status_i,
  output gme_pkg::ctrl_cmd_t    cmd_o
);
  import gme_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!status_i.mode_err && status_i.need_div) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (status_i.out_free && status_i.pix_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/gme_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph mask expander datapath
// Configuration registers, position counters, an eight-step restoring
// divider for gray scaling, pixel unpacking and the output register.
// ----------------------------------------------------------------------------
module gme_dp #(
  parameter int unsigned MAX_WIDTH    = gme_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT   = gme_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned GUARD_PIXELS = gme_pkg::DEF_GUARD_PIXELS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gme_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gme_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  input  logic [gme_pkg::BYTE_W-1:0]      in_data_byte_i,
  input  gme_pkg::ctrl_cmd_t              cmd_i,
  output gme_pkg::ctrl_status_t           status_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [gme_pkg::COORD_W-1:0]     out_pos_x_o,
  output logic [gme_pkg::COORD_W-1:0]     out_pos_y_o,
  output logic [gme_pkg::BYTE_W-1:0]      out_alpha_value_o,
  output logic                            out_mode_error_o,
  output logic                            out_last_of_run_o,
  output logic                            out_frame_done_o
);
  import gme_pkg::*;

  localparam int unsigned CNT_W = 3;
  localparam int unsigned SUM_W = COORD_W + 1;

  // Configuration registers.
  logic [COORD_W-1:0]  src_width_q, src_height_q;
  logic [MODE_W-1:0]   pixel_mode_q;
  logic [LEVELS_W-1:0] gray_levels_q;
  logic                rows_reversed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q     <= RST_SRC_WIDTH;
      src_height_q    <= RST_SRC_HEIGHT;
      pixel_mode_q    <= MODE_W'(MODE_GRAY);
      gray_levels_q   <= RST_GRAY_LEVELS;
      rows_reversed_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SRC_WIDTH:     src_width_q     <= cfg_data_i;
        CFG_SRC_HEIGHT:    src_height_q    <= cfg_data_i;
        CFG_PIXEL_MODE:    pixel_mode_q    <= cfg_data_i[MODE_W-1:0];
        CFG_GRAY_LEVELS:   gray_levels_q   <= cfg_data_i[LEVELS_W-1:0];
        CFG_ROWS_REVERSED: rows_reversed_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective dimensions: zero counts as one, large values saturate.
  logic [COORD_W-1:0] width_eff, height_eff;

  always_comb begin
    if (src_width_q == '0) begin
      width_eff = COORD_W'(1);
    end else if ({2'b00, src_width_q} > DIM_CMP_W'(MAX_WIDTH)) begin
      width_eff = COORD_W'(MAX_WIDTH);
    end else begin
      width_eff = src_width_q;
    end
    if (src_height_q == '0) begin
      height_eff = COORD_W'(1);
    end else if ({2'b00, src_height_q} > DIM_CMP_W'(MAX_HEIGHT)) begin
      height_eff = COORD_W'(MAX_HEIGHT);
    end else begin
      height_eff = src_height_q;
    end
  end

  // Mode decode and gray divisor.
  logic                mode_err, mode_mono, gray_copy;
  logic [LEVELS_W-1:0] divisor;

  assign mode_err  = (pixel_mode_q != MODE_W'(MODE_GRAY)) &&
                     (pixel_mode_q != MODE_W'(MODE_MONO));
  assign mode_mono = (pixel_mode_q == MODE_W'(MODE_MONO));
  assign gray_copy = (gray_levels_q == LEVELS_COPY);
  assign divisor   = (gray_levels_q > LEVELS_W'(1)) ? gray_levels_q - LEVELS_W'(1)
                                                    : LEVELS_W'(1);

  // Word, step counter and position counters.
  logic [BYTE_W-1:0]  byte_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [COORD_W-1:0] col_q, col_d, row_q, row_d;
  logic               emit_fire;

  assign emit_fire = cmd_i.emit && status_o.out_free;

  // Pixel column for the current step.
  logic [SUM_W-1:0]   pix_col_sum;
  logic [COORD_W-1:0] pix_col;
  logic               row_end;

  assign pix_col_sum = {1'b0, col_q} + SUM_W'(cnt_q);
  assign pix_col     = pix_col_sum[COORD_W-1:0];
  assign row_end     = (pix_col == width_eff - COORD_W'(1));

  // Counter updates: rewrap on load, advance after the last pixel of a word.
  logic [SUM_W-1:0] row_inc_load, row_inc_emit;

  assign row_inc_load = ({1'b0, col_q} >= {1'b0, width_eff}) ?
                        {1'b0, row_q} + SUM_W'(1) : {1'b0, row_q};
  assign row_inc_emit = {1'b0, row_q} + SUM_W'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      cnt_d = '0;
      if (!mode_err) begin
        if (col_q >= width_eff) begin
          col_d = '0;
        end
        if (row_inc_load >= {1'b0, height_eff}) begin
          row_d = '0;
        end else begin
          row_d = row_inc_load[COORD_W-1:0];
        end
      end
    end else if (cmd_i.div_step) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (emit_fire) begin
      if (status_o.pix_last) begin
        if (!mode_err) begin
          if (row_end) begin
            col_d = '0;
            if (row_inc_emit >= {1'b0, height_eff}) begin
              row_d = '0;
            end else begin
              row_d = row_inc_emit[COORD_W-1:0];
            end
          end else begin
            col_d = pix_col + COORD_W'(1);
          end
        end
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= in_data_byte_i;
    end
  end

  // Restoring divider: byte * 255 / divisor, eight quotient bits.
  // A quotient of 256 or more is caught at load from the upper byte.
  logic [2*BYTE_W-1:0] num_in;
  logic [LEVELS_W-1:0] rem_q;
  logic [BYTE_W-1:0]   lo_q, quot_q;
  logic                sat_q;
  logic [LEVELS_W:0]   rem_shift;
  logic                q_bit;

  assign num_in    = {in_data_byte_i, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, in_data_byte_i};
  assign rem_shift = {rem_q, lo_q[BYTE_W-1]};
  assign q_bit     = (rem_shift >= {1'b0, divisor});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q  <= {1'b0, num_in[2*BYTE_W-1:BYTE_W]};
      lo_q   <= num_in[BYTE_W-1:0];
      sat_q  <= ({1'b0, num_in[2*BYTE_W-1:BYTE_W]} >= divisor);
      quot_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= q_bit ? LEVELS_W'(rem_shift - {1'b0, divisor}) : rem_shift[LEVELS_W-1:0];
      lo_q   <= {lo_q[BYTE_W-2:0], 1'b0};
      quot_q <= {quot_q[BYTE_W-2:0], q_bit};
    end
  end

  // Pixel value, coordinates and flags for the current step.
  logic [BYTE_W-1:0]  byte_shift, alpha;
  logic [COORD_W-1:0] row_tgt, pos_x, pos_y;
  logic               frame_end;

  assign byte_shift = byte_q << cnt_q;

  always_comb begin
    if (mode_err) begin
      alpha = '0;
    end else if (mode_mono) begin
      alpha = byte_shift[BYTE_W-1] ? ALPHA_FULL : '0;
    end else if (gray_copy) begin
      alpha = byte_q;
    end else begin
      alpha = sat_q ? ALPHA_FULL : quot_q;
    end
  end

  assign row_tgt   = rows_reversed_q ? height_eff - COORD_W'(1) - row_q : row_q;
  assign pos_x     = mode_err ? '0 : pix_col + COORD_W'(GUARD_PIXELS);
  assign pos_y     = mode_err ? '0 : row_tgt + COORD_W'(GUARD_PIXELS);
  assign frame_end = !mode_err && row_end && (row_q == height_eff - COORD_W'(1));

  // Status to the controller.
  assign status_o.mode_err = mode_err;
  assign status_o.need_div = !mode_mono && !gray_copy;
  assign status_o.div_last = (cnt_q == {CNT_W{1'b1}});
  assign status_o.pix_last = mode_err || !mode_mono || row_end ||
                             (cnt_q == {CNT_W{1'b1}});
  assign status_o.out_free = !out_valid_o || out_ready_i;

  // Output register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_pos_x_o       <= pos_x;
      out_pos_y_o       <= pos_y;
      out_alpha_value_o <= alpha;
      out_mode_error_o  <= mode_err;
      out_last_of_run_o <= status_o.pix_last;
      out_frame_done_o  <= frame_end;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/glyph_mask_expander_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph mask expander
// Turns rasterized glyph bytes into 8-bit alpha pixels placed in a bitmap
// with a transparent guard border.
// ----------------------------------------------------------------------------
// One input word is handled at a time. A mono word is accepted and then yields
// one pixel per cycle while the output register is free. A gray word is either
// copied or scaled, and the scaling runs through an eight-step restoring
// divider. An unsupported mode yields one error word. The output register
// lets the next word be accepted while the last pixel still waits to be
// taken. Configuration must be written only while the unit is idle; the
// unit itself does not enforce this.
module glyph_mask_expander_unit #(
  parameter int unsigned MAX_WIDTH    = gme_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT   = gme_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned GUARD_PIXELS = gme_pkg::DEF_GUARD_PIXELS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gme_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gme_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gme_pkg::BYTE_W-1:0]    in_data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gme_pkg::COORD_W-1:0]   out_pos_x_o,
  output logic [gme_pkg::COORD_W-1:0]   out_pos_y_o,
  output logic [gme_pkg::BYTE_W-1:0]    out_alpha_value_o,
  output logic                          out_mode_error_o,
  output logic                          out_last_of_run_o,
  output logic                          out_frame_done_o
);
  import gme_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Sequencer.
  gme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Counters, divider and output register.
  gme_dp #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .GUARD_PIXELS (GUARD_PIXELS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_data_byte_i    (in_data_byte_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_pos_x_o       (out_pos_x_o),
    .out_pos_y_o       (out_pos_y_o),
    .out_alpha_value_o (out_alpha_value_o),
    .out_mode_error_o  (out_mode_error_o),
    .out_last_of_run_o (out_last_of_run_o),
    .out_frame_done_o  (out_frame_done_o)
  );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph mask expander testbench
// Feeds source bytes through a valid/ready driver under many register setups,
// directed first and then random. Every pixel word is checked field by field
// against a behavioral expansion of the same bytes, with random idle cycles
// on the sending side and random stalls on the receiving side.
// ----------------------------------------------------------------------------
module tb;
  import gme_pkg::*;

  localparam int unsigned MAX_W        = DEF_MAX_WIDTH;
  localparam int unsigned MAX_H        = DEF_MAX_HEIGHT;
  localparam int unsigned GUARD        = DEF_GUARD_PIXELS;
  localparam int          CLK_HALF     = 6;
  localparam int          RANDOM_ITEMS = 80;
  localparam int          SETTLE       = 16;
  localparam int          CYCLE_LIMIT  = 300000;
  localparam int          REPORT_MAX   = 10;

  // Mode codes that the unit does not support.
  localparam logic [MODE_W-1:0] MODE_BAD_2 = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BAD_3 = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [BYTE_W-1:0]  alpha;
    logic               mode_err;
    logic               last_of_run;
    logic               frame_done;
  } pixel_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic [BYTE_W-1:0]    in_byte = '0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic                 out_ready = 1'b0;
  logic [COORD_W-1:0]   out_pos_x_o;
  logic [COORD_W-1:0]   out_pos_y_o;
  logic [BYTE_W-1:0]    out_alpha_value_o;
  logic                 out_mode_error_o;
  logic                 out_last_of_run_o;
  logic                 out_frame_done_o;

  glyph_mask_expander_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .in_data_byte_i    (in_byte),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .out_pos_x_o       (out_pos_x_o),
    .out_pos_y_o       (out_pos_y_o),
    .out_alpha_value_o (out_alpha_value_o),
    .out_mode_error_o  (out_mode_error_o),
    .out_last_of_run_o (out_last_of_run_o),
    .out_frame_done_o  (out_frame_done_o)
  );

  // Shadow copy of the registers and of the raster position.
  logic [COORD_W-1:0]  sh_width = RST_SRC_WIDTH;
  logic [COORD_W-1:0]  sh_height = RST_SRC_HEIGHT;
  logic [MODE_W-1:0]   sh_mode = MODE_GRAY;
  logic [LEVELS_W-1:0] sh_levels = RST_GRAY_LEVELS;
  logic                sh_rev = 1'b0;
  int                  cur_col = 0;
  int                  cur_row = 0;

  logic [BYTE_W-1:0] pending_bytes[$];
  pixel_t            expected_pixels[$];

  int gap_max = 4;
  int stall_max = 4;
  int send_gap = 0;
  int stall_left = 0;
  int cycle_cnt = 0;
  int fail_cnt = 0;
  int n_bytes = 0;
  int n_pixels = 0;
  int n_frames = 0;
  int n_mode_err = 0;
  int n_setups = 0;

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // A zero dimension counts as one, a large one saturates.
  function automatic int fit_dim(int v, int lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [BYTE_W-1:0] scale_gray(logic [BYTE_W-1:0] b);
    int d;
    int v;
    if (sh_levels == LEVELS_COPY) return b;
    d = (sh_levels > 1) ? int'(sh_levels) - 1 : 1;
    v = (int'(b) * int'(ALPHA_FULL)) / d;
    return (v > int'(ALPHA_FULL)) ? ALPHA_FULL : BYTE_W'(v);
  endfunction

  // Expands one accepted byte into the pixel words it must produce.
  task automatic expand_byte(logic [BYTE_W-1:0] b);
    int     w;
    int     h;
    int     cnt;
    int     ty;
    int     col;
    bit     last_row;
    pixel_t px;
    w = fit_dim(sh_width, MAX_W);
    h = fit_dim(sh_height, MAX_H);
    n_bytes++;
    px = '0;
    if (sh_mode != MODE_GRAY && sh_mode != MODE_MONO) begin
      px.mode_err = 1'b1;
      px.last_of_run = 1'b1;
      expected_pixels.insert(expected_pixels.size(), px);
      n_mode_err++;
      return;
    end
    // Counters left out of range by a register change wrap first.
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= h) cur_row = 0;
    ty = (sh_rev ? (h - 1 - cur_row) : cur_row) + GUARD;
    last_row = (cur_row == h - 1);
    cnt = (sh_mode == MODE_GRAY) ? 1 : ((w - cur_col > 8) ? 8 : w - cur_col);
    for (int i = 0; i < cnt; i++) begin
      col = cur_col + i;
      px.pos_x = COORD_W'(col + GUARD);
      px.pos_y = COORD_W'(ty);
      if (sh_mode == MODE_GRAY) px.alpha = scale_gray(b);
      else px.alpha = b[7 - i] ? ALPHA_FULL : '0;
      px.last_of_run = (i == cnt - 1);
      px.frame_done = last_row && (col == w - 1);
      if (px.frame_done) n_frames++;
      expected_pixels.insert(expected_pixels.size(), px);
      n_pixels++;
    end
    cur_col += cnt;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= h) cur_row = 0;
    end
  endtask

  // Driver: presents queued bytes, with a random gap before each one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_byte  <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready_o) expand_byte(in_byte);
      if (!in_valid || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_valid <= 1'b1;
          in_byte  <= pending_bytes[0];
          pending_bytes.delete(0);
          send_gap <= $urandom_range(0, gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes pixel words with random stalls and checks each one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid_o && out_ready) begin
      if (expected_pixels.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX)
          $display("unexpected pixel word x=%0d y=%0d a=%0d err=%0d last=%0d done=%0d",
                   out_pos_x_o, out_pos_y_o, out_alpha_value_o, out_mode_error_o,
                   out_last_of_run_o, out_frame_done_o);
      end else begin
        automatic pixel_t ex;
        ex = expected_pixels[0];
        expected_pixels.delete(0);
        if (ex.pos_x != out_pos_x_o || ex.pos_y != out_pos_y_o ||
            ex.alpha != out_alpha_value_o || ex.mode_err != out_mode_error_o ||
            ex.last_of_run != out_last_of_run_o || ex.frame_done != out_frame_done_o) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX)
            $display("pixel mismatch: expected x=%0d y=%0d a=%0d err=%0d last=%0d done=%0d, got x=%0d y=%0d a=%0d err=%0d last=%0d done=%0d",
                     ex.pos_x, ex.pos_y, ex.alpha, ex.mode_err, ex.last_of_run,
                     ex.frame_done, out_pos_x_o, out_pos_y_o, out_alpha_value_o,
                     out_mode_error_o, out_last_of_run_o, out_frame_done_o);
        end
      end
      begin
        automatic int s = $urandom_range(0, stall_max);
        stall_left <= s;
        out_ready  <= (s == 0);
      end
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixel words outstanding",
               cycle_cnt, expected_pixels.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(cfg_index_e idx, logic [CFG_DAT_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SRC_WIDTH:     sh_width = val;
      CFG_SRC_HEIGHT:    sh_height = val;
      CFG_PIXEL_MODE:    sh_mode = val[MODE_W-1:0];
      CFG_GRAY_LEVELS:   sh_levels = val[LEVELS_W-1:0];
      CFG_ROWS_REVERSED: sh_rev = val[0];
      default: ;
    endcase
  endtask

  task automatic setup(int w, int h, logic [MODE_W-1:0] mode, int levels, bit rev);
    write_reg(CFG_SRC_WIDTH, CFG_DAT_W'(w));
    write_reg(CFG_SRC_HEIGHT, CFG_DAT_W'(h));
    write_reg(CFG_PIXEL_MODE, CFG_DAT_W'(mode));
    write_reg(CFG_GRAY_LEVELS, CFG_DAT_W'(levels));
    write_reg(CFG_ROWS_REVERSED, CFG_DAT_W'(rev));
    n_setups++;
  endtask

  // Holds the sender back until every pixel word has come, then lets the
  // unit settle so registers can be written safely.
  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic send_bytes(logic [BYTE_W-1:0] list[$]);
    foreach (list[i]) pending_bytes.insert(pending_bytes.size(), list[i]);
    drain();
  endtask

  initial begin
    int                w;
    int                h;
    int                lv;
    int                roll;
    int                bpr;
    int                cnt;
    int                sent;
    logic [MODE_W-1:0] md;
    logic [BYTE_W-1:0] b;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Reset values: a 1x1 gray bitmap copied as is.
    send_bytes('{8'h00, 8'hFF});
    // Plain copy over a full 3x2 frame.
    setup(3, 2, MODE_GRAY, 256, 1'b0);
    send_bytes('{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hAA});
    // Scaled gray with saturation, rows bottom-up.
    setup(2, 2, MODE_GRAY, 16, 1'b1);
    send_bytes('{8'h00, 8'h0F, 8'h10, 8'hFF});
    // Level counts of zero and one divide by one; above 256 still scales.
    setup(1, 1, MODE_GRAY, 0, 1'b0);
    send_bytes('{8'h80});
    setup(1, 1, MODE_GRAY, 1, 1'b0);
    send_bytes('{8'h01});
    setup(1, 1, MODE_GRAY, 511, 1'b0);
    send_bytes('{8'hFF});
    // Mono rows of ten pixels: the second byte of each row is cut short.
    setup(10, 2, MODE_MONO, 256, 1'b1);
    send_bytes('{8'hA5, 8'hC0, 8'hFF, 8'h01});
    // Narrowing the width mid-row forces a wrap to the next row.
    send_bytes('{8'h5A});
    setup(4, 2, MODE_MONO, 256, 1'b1);
    send_bytes('{8'h3C});
    // Unsupported modes give one error word each.
    setup(4, 2, MODE_BAD_2, 256, 1'b0);
    send_bytes('{8'h77});
    setup(4, 2, MODE_BAD_3, 256, 1'b0);
    send_bytes('{8'h88});
    // Zero dimensions count as one; oversize ones saturate.
    setup(0, 0, MODE_GRAY, 256, 1'b0);
    send_bytes('{8'h42});
    setup(2047, 2047, MODE_GRAY, 256, 1'b1);
    send_bytes('{8'h24});

    // Random setups, mostly small bitmaps sent as whole frames.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 9);
      if (roll < 8) w = $urandom_range(1, 12);
      else if (roll == 8) w = $urandom_range(0, 2047);
      else begin
        case ($urandom_range(0, 2))
          0: w = 0;
          1: w = 1024;
          default: w = 2047;
        endcase
      end
      roll = $urandom_range(0, 9);
      if (roll < 8) h = $urandom_range(1, 4);
      else if (roll == 8) h = $urandom_range(0, 2047);
      else h = ($urandom_range(0, 1) != 0) ? 1024 : 0;
      roll = $urandom_range(0, 19);
      if (roll < 9) md = MODE_GRAY;
      else if (roll < 18) md = MODE_MONO;
      else if (roll == 18) md = MODE_BAD_2;
      else md = MODE_BAD_3;
      roll = $urandom_range(0, 9);
      case (roll)
        0, 1, 2, 3: lv = 256;
        4: lv = 0;
        5: lv = 1;
        6: lv = 511;
        7: lv = 257;
        default: lv = $urandom_range(2, 255);
      endcase
      gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 4;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
      setup(w, h, md, lv, $urandom_range(0, 1));

      bpr = fit_dim(w, MAX_W);
      if (md == MODE_MONO) bpr = (bpr + 7) / 8;
      if (md != MODE_GRAY && md != MODE_MONO) cnt = $urandom_range(1, 3);
      else if (bpr * fit_dim(h, MAX_H) <= 24) cnt = bpr * fit_dim(h, MAX_H);
      else cnt = $urandom_range(4, 16);
      for (int i = 0; i < cnt; i++) begin
        roll = $urandom_range(0, 19);
        if (roll < 3) b = 8'h00;
        else if (roll < 6) b = 8'hFF;
        else b = $urandom_range(0, 255);
        pending_bytes.insert(pending_bytes.size(), b);
      end
      sent += cnt;
      drain();
    end

    if (expected_pixels.size() != 0) begin
      fail_cnt++;
      $display("%0d pixel words never arrived", expected_pixels.size());
    end
    $display("Ran %0d register setups and %0d source bytes in %0d cycles.",
             n_setups, n_bytes, cycle_cnt);
    $display("Checked %0d pixels over %0d finished frames, plus %0d mode errors.",
             n_pixels, n_frames, n_mode_err);
    if (fail_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
